/* rtl/core/talca_pkg.sv */
// Shared types and constants of the binary-lifting lowest-common-ancestor engine.
package talca_pkg;

   localparam int MaxNodesDefault   = 1024;
   localparam int LiftLevelsDefault = 20;
   localparam int LevelW            = 10;
   localparam int NodeFieldW        = 10;
   localparam int CountW            = 11;
   localparam int PathW             = 11;
   localparam int PathMax           = 2046;
   localparam int NodeCountReset    = 1024;

   typedef enum logic [1:0] {
      FUNC_LOAD  = 2'd0,
      FUNC_BUILD = 2'd1,
      FUNC_QUERY = 2'd2,
      FUNC_NOP   = 2'd3
   } func_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_BLD_RD0,
      ST_BLD_RD1,
      ST_BLD_WR,
      ST_Q_LVL,
      ST_Q_LVLW,
      ST_Q_DIFF,
      ST_CLB_RD,
      ST_CLB_WT,
      ST_CLB_STEP,
      ST_Q_CMP,
      ST_BS_MID,
      ST_BS_CMP,
      ST_Q_LVW,
      ST_Q_LVWW,
      ST_Q_DONE
   } state_type;

   typedef enum logic [1:0] {
      C_IDLE,
      C_SCAN,
      C_WAIT,
      C_TAKE
   } climb_state_type;

endpackage

/* rtl/core/talca_climb.sv */
// Shared climb unit: lifts one node by a step count, one table read per set bit.
module talca_climb #(
   parameter int MAX_NODES   = talca_pkg::MaxNodesDefault,
   parameter int LIFT_LEVELS = talca_pkg::LiftLevelsDefault,
   localparam int NW = $clog2(MAX_NODES) + 1,
   localparam int KW = $clog2(LIFT_LEVELS)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   go,
   input  logic [NW-1:0]          node,
   input  logic [LIFT_LEVELS-1:0] steps,
   output logic [NW-2:0]          rd_node,
   output logic [KW-1:0]          rd_level,
   input  logic [NW-1:0]          rd_data,
   output logic                   done,
   output logic [NW-1:0]          result
);
   localparam logic [NW-1:0] NoneCode = NW'(MAX_NODES);

   talca_pkg::climb_state_type st_ff, st_in;
   logic [NW-1:0]          x_ff, x_in;
   logic [LIFT_LEVELS-1:0] s_ff, s_in;
   logic [KW-1:0]          k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= talca_pkg::C_IDLE;
      end else begin
         st_ff <= st_in;
      end
      x_ff <= x_in;
      s_ff <= s_in;
      k_ff <= k_in;
   end

   always_comb begin
      st_in    = st_ff;
      x_in     = x_ff;
      s_in     = s_ff;
      k_in     = k_ff;
      rd_node  = x_ff[NW-2:0];
      rd_level = k_ff;
      done     = 1'b0;
      result   = x_ff;
      case (st_ff)
         talca_pkg::C_IDLE: begin
            if (go) begin
               x_in  = node;
               s_in  = steps;
               k_in  = KW'(LIFT_LEVELS - 1);
               st_in = talca_pkg::C_SCAN;
            end
         end
         talca_pkg::C_SCAN: begin
            // skip clear bits, and every bit once at none
            if (s_ff[k_ff] && x_ff < NoneCode) begin
               st_in = talca_pkg::C_WAIT;
            end else if (k_ff == '0) begin
               done  = 1'b1;
               st_in = talca_pkg::C_IDLE;
            end else begin
               k_in = k_ff - 1'b1;
            end
         end
         talca_pkg::C_WAIT: begin
            st_in = talca_pkg::C_TAKE;
         end
         talca_pkg::C_TAKE: begin
            x_in = rd_data;
            if (k_ff == '0) begin
               st_in = talca_pkg::C_IDLE;
               done  = 1'b1;
               result = rd_data;
            end else begin
               k_in  = k_ff - 1'b1;
               st_in = talca_pkg::C_SCAN;
            end
         end
         default: st_in = talca_pkg::C_IDLE;
      endcase
   end
endmodule

/* rtl/core/tree_ancestor_lca_engine.sv */
// Top level of the binary-lifting lowest-common-ancestor engine.
// Usage: drive req_* with start high while busy is low to hand over one word.
//   func load writes a node's parent (or none) and its depth in the accepting
//   cycle; busy never rises, so loads can follow back to back.
//   func build doubles the ancestor table over min(node_count, MAX_NODES)
//   rows and LIFT_LEVELS-1 columns, each entry by two reads and a write.
//   func query answers with one rsp_* word marked by rsp_valid for one cycle:
//   two level reads and one lift climb; then, unless the lifted node meets
//   the other, a binary search of about log2(depth) rounds of two climbs and
//   a final climb; then a level read of the ancestor. A climb scans every
//   step bit from the top, with one ancestor read per set bit. The word
//   shows in the cycle busy falls. A faulting query never raises busy; its
//   word shows in the cycle after acceptance.
// The receiver cannot stall: rsp_valid marks the result word for exactly one
// cycle and is never held.
// csr_wr_en/csr_wr_data write node_count at any edge; write only when idle.
// Reset clears control state and sets node_count to 1024; tables stay
// undefined until loaded, so no clearing pass is run.
module tree_ancestor_lca_engine #(
   parameter int MAX_NODES   = talca_pkg::MaxNodesDefault,
   parameter int LIFT_LEVELS = talca_pkg::LiftLevelsDefault
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_func,
   input  logic [talca_pkg::NodeFieldW-1:0]  req_node_a,
   input  logic [talca_pkg::NodeFieldW-1:0]  req_node_b,
   input  logic                              req_is_root,
   input  logic [talca_pkg::LevelW-1:0]      req_node_level,
   output logic                              rsp_valid,
   output logic [talca_pkg::NodeFieldW-1:0]  rsp_ancestor,
   output logic [talca_pkg::PathW-1:0]       rsp_path_length,
   output logic                              rsp_fault,
   input  logic                              csr_wr_en,
   input  logic [talca_pkg::CountW-1:0]      csr_wr_data
);
   localparam int NW = $clog2(MAX_NODES) + 1;   // node code incl. none
   localparam int AW = NW - 1;                  // node address
   localparam int KW = $clog2(LIFT_LEVELS);
   localparam int LW = talca_pkg::LevelW;
   localparam int FW = talca_pkg::NodeFieldW;
   localparam int CW = talca_pkg::CountW;
   localparam int PW = talca_pkg::PathW;
   localparam int DEPTH = MAX_NODES * LIFT_LEVELS;
   localparam int MW = $clog2(DEPTH);
   localparam logic [NW-1:0] NoneCode = NW'(MAX_NODES);
   localparam int EW = (NW > FW ? NW : FW) + 1;
   localparam int SW = (CW > NW ? CW : NW) + 1;

   // ancestor memory, row-major: node * LIFT_LEVELS + level
   logic [NW-1:0] anc_mem [DEPTH];
   logic [LW-1:0] lvl_mem [MAX_NODES];

   logic          anc_we;
   logic [MW-1:0] anc_waddr, anc_raddr;
   logic [NW-1:0] anc_wdata, anc_rdata_ff;
   logic          lvl_we;
   logic [AW-1:0] lvl_waddr, lvl_raddr;
   logic [LW-1:0] lvl_wdata, lvl_rdata_ff;

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[anc_waddr] <= anc_wdata;
      end
      anc_rdata_ff <= anc_mem[anc_raddr];
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         lvl_mem[lvl_waddr] <= lvl_wdata;
      end
      lvl_rdata_ff <= lvl_mem[lvl_raddr];
   end

   function automatic logic [MW-1:0] addr_of(logic [AW-1:0] n, logic [KW-1:0] k);
      logic [MW+KW:0] a;
      begin
         a = (MW+KW+1)'(n) * (MW+KW+1)'(LIFT_LEVELS) + (MW+KW+1)'(k);
         return a[MW-1:0];
      end
   endfunction

   // node_count register
   logic [CW-1:0] ncount_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         ncount_ff <= CW'(talca_pkg::NodeCountReset);
      end else if (csr_wr_en) begin
         ncount_ff <= csr_wr_data;
      end
   end
   logic [SW-1:0] active;
   assign active = (SW'(ncount_ff) > SW'(MAX_NODES)) ? SW'(MAX_NODES) : SW'(ncount_ff);

   // climb unit
   logic                   cl_go, cl_done;
   logic [NW-1:0]          cl_node, cl_result;
   logic [LIFT_LEVELS-1:0] cl_steps;
   logic [AW-1:0]          cl_rd_node;
   logic [KW-1:0]          cl_rd_level;

   talca_climb #(.MAX_NODES(MAX_NODES), .LIFT_LEVELS(LIFT_LEVELS)) u_climb (
      .clock(clock), .reset(reset), .go(cl_go), .node(cl_node), .steps(cl_steps),
      .rd_node(cl_rd_node), .rd_level(cl_rd_level),
      .rd_data(anc_rdata_ff), .done(cl_done), .result(cl_result)
   );

   talca_pkg::state_type st_ff, st_in;
   logic [AW-1:0] j_ff, j_in;          // build row
   logic [KW-1:0] k_ff, k_in;          // build column
   logic [NW-1:0] u_ff, u_in, v_ff, v_in;
   logic [LW-1:0] lu_ff, lu_in, lv_ff, lv_in, lw_ff, lw_in;
   logic [LW:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic [NW-1:0] cu_ff, cu_in;
   logic [1:0]    phase_ff, phase_in;  // which climb is running
   logic          rv_ff, rv_in, rf_ff, rf_in;
   logic [FW-1:0] ra_ff, ra_in;
   logic [PW-1:0] rp_ff, rp_in;
   logic [NW-1:0] w_ff, w_in;

   localparam logic [1:0] PH_LIFT = 2'd0, PH_U = 2'd1, PH_V = 2'd2, PH_FIN = 2'd3;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= talca_pkg::ST_IDLE;
         rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         rv_ff <= rv_in;
      end
      j_ff <= j_in;   k_ff <= k_in;
      u_ff <= u_in;   v_ff <= v_in;
      lu_ff <= lu_in; lv_ff <= lv_in; lw_ff <= lw_in;
      lo_ff <= lo_in; hi_ff <= hi_in;
      cu_ff <= cu_in; phase_ff <= phase_in;
      rf_ff <= rf_in; ra_ff <= ra_in; rp_ff <= rp_in; w_ff <= w_in;
   end

   assign rsp_valid       = rv_ff;
   assign rsp_ancestor    = ra_ff;
   assign rsp_path_length = rp_ff;
   assign rsp_fault       = rf_ff;
   assign busy = (st_ff != talca_pkg::ST_IDLE);

   logic [LW:0]   mid;
   logic signed [LW+2:0] plen;
   assign mid  = (lo_ff + hi_ff) >> 1;
   assign plen = $signed({3'b0, lu_ff}) + $signed({3'b0, lv_ff})
               - $signed({2'b0, lw_ff, 1'b0});

   always_comb begin
      st_in = st_ff; j_in = j_ff; k_in = k_ff; u_in = u_ff; v_in = v_ff;
      lu_in = lu_ff; lv_in = lv_ff; lw_in = lw_ff; lo_in = lo_ff; hi_in = hi_ff;
      cu_in = cu_ff; phase_in = phase_ff; rv_in = 1'b0; rf_in = rf_ff;
      ra_in = ra_ff; rp_in = rp_ff; w_in = w_ff;
      anc_we = 1'b0; anc_waddr = '0; anc_wdata = '0;
      lvl_we = 1'b0; lvl_waddr = req_node_a[AW-1:0]; lvl_wdata = req_node_level;
      lvl_raddr = u_ff[AW-1:0];
      anc_raddr = addr_of(cl_rd_node, cl_rd_level);
      cl_go = 1'b0; cl_node = u_ff; cl_steps = '0;
      case (st_ff)
         talca_pkg::ST_IDLE: begin
            if (start) begin
               case (talca_pkg::func_type'(req_func))
                  talca_pkg::FUNC_LOAD: begin
                     // ignore nodes past the memory
                     if (EW'(req_node_a) < EW'(MAX_NODES)) begin
                        anc_we    = 1'b1;
                        anc_waddr = addr_of(req_node_a[AW-1:0], '0);
                        anc_wdata = (req_is_root || EW'(req_node_b) >= EW'(MAX_NODES))
                                    ? NoneCode : NW'(req_node_b);
                        lvl_we    = 1'b1;
                     end
                  end
                  talca_pkg::FUNC_BUILD: begin
                     j_in = '0;
                     k_in = '0;
                     if (active != '0 && LIFT_LEVELS > 1) begin
                        st_in = talca_pkg::ST_BLD_RD0;
                     end
                  end
                  talca_pkg::FUNC_QUERY: begin
                     if (SW'(req_node_a) >= active || SW'(req_node_b) >= active) begin
                        rv_in = 1'b1; rf_in = 1'b1; ra_in = '0; rp_in = '0;
                     end else begin
                        rf_in = 1'b0;
                        u_in  = NW'(req_node_a);
                        v_in  = NW'(req_node_b);
                        st_in = talca_pkg::ST_Q_LVL;
                     end
                  end
                  default: ;
               endcase
            end
         end
         // build: mid = anc[j][k]; anc[j][k+1] = anc[mid][k] or none
         talca_pkg::ST_BLD_RD0: begin
            anc_raddr = addr_of(j_ff, k_ff);
            st_in = talca_pkg::ST_BLD_RD1;
         end
         talca_pkg::ST_BLD_RD1: begin
            cu_in = anc_rdata_ff;
            anc_raddr = addr_of(anc_rdata_ff[AW-1:0], k_ff);
            st_in = talca_pkg::ST_BLD_WR;
         end
         talca_pkg::ST_BLD_WR: begin
            anc_we    = 1'b1;
            anc_waddr = addr_of(j_ff, k_ff + 1'b1);
            anc_wdata = (cu_ff < NoneCode) ? anc_rdata_ff : NoneCode;
            st_in = talca_pkg::ST_BLD_RD0;
            if (SW'(j_ff) + 1'b1 >= active) begin
               j_in = '0;
               if (32'(k_ff) + 2 >= LIFT_LEVELS) begin
                  st_in = talca_pkg::ST_IDLE;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         // read both levels
         talca_pkg::ST_Q_LVL: begin
            lvl_raddr = u_ff[AW-1:0];
            st_in = talca_pkg::ST_Q_LVLW;
         end
         talca_pkg::ST_Q_LVLW: begin
            lvl_raddr = v_ff[AW-1:0];
            lu_in = lvl_rdata_ff;
            st_in = talca_pkg::ST_Q_DIFF;
         end
         talca_pkg::ST_Q_DIFF: begin
            // swap so u is the deeper node, then lift it
            lv_in = lvl_rdata_ff;
            phase_in = PH_LIFT;
            cl_go = 1'b1;
            if (lvl_rdata_ff > lu_ff) begin
               u_in = v_ff; v_in = u_ff;
               cl_node  = v_ff;
               cl_steps = LIFT_LEVELS'(lvl_rdata_ff - lu_ff);
            end else begin
               cl_node  = u_ff;
               cl_steps = LIFT_LEVELS'(lu_ff - lvl_rdata_ff);
            end
            st_in = talca_pkg::ST_CLB_WT;
         end
         talca_pkg::ST_CLB_WT: begin
            if (cl_done) begin
               case (phase_ff)
                  PH_LIFT: begin
                     u_in  = cl_result;
                     st_in = talca_pkg::ST_Q_CMP;
                  end
                  PH_U: begin
                     cu_in = cl_result;
                     phase_in = PH_V;
                     st_in = talca_pkg::ST_CLB_RD;
                  end
                  PH_V: begin
                     if (cu_ff == cl_result) hi_in = mid;
                     else lo_in = mid;
                     st_in = talca_pkg::ST_BS_CMP;
                  end
                  default: begin
                     w_in  = cl_result;
                     st_in = talca_pkg::ST_Q_LVW;
                  end
               endcase
            end
         end
         talca_pkg::ST_CLB_RD: begin
            cl_go = 1'b1;
            cl_node  = (phase_ff == PH_V) ? v_ff : u_ff;
            cl_steps = (phase_ff == PH_FIN) ? LIFT_LEVELS'(hi_ff) : LIFT_LEVELS'(mid);
            st_in = talca_pkg::ST_CLB_WT;
         end
         talca_pkg::ST_Q_CMP: begin
            if (u_ff == v_ff) begin
               w_in  = u_ff;
               st_in = talca_pkg::ST_Q_LVW;
            end else begin
               // search bound from the lifted node's level
               lvl_raddr = u_ff[AW-1:0];
               lo_in = '0;
               st_in = talca_pkg::ST_BS_MID;
            end
         end
         talca_pkg::ST_BS_MID: begin
            hi_in = (u_ff < NoneCode) ? ({1'b0, lvl_rdata_ff} + 1'b1) : (LW+1)'(1);
            st_in = talca_pkg::ST_BS_CMP;
         end
         talca_pkg::ST_BS_CMP: begin
            st_in = talca_pkg::ST_CLB_RD;
            phase_in = (hi_ff - lo_ff > 1) ? PH_U : PH_FIN;
         end
         talca_pkg::ST_Q_LVW: begin
            lvl_raddr = w_ff[AW-1:0];
            st_in = talca_pkg::ST_Q_LVWW;
         end
         talca_pkg::ST_Q_LVWW: begin
            lw_in = (w_ff < NoneCode) ? lvl_rdata_ff : '0;
            st_in = talca_pkg::ST_Q_DONE;
         end
         talca_pkg::ST_Q_DONE: begin
            rv_in = 1'b1;
            ra_in = (w_ff < NoneCode) ? FW'(w_ff) : '0;
            if (plen < 0) rp_in = '0;
            else if (plen > talca_pkg::PathMax) rp_in = PW'(talca_pkg::PathMax);
            else rp_in = PW'(plen);
            st_in = talca_pkg::ST_IDLE;
         end
         default: st_in = talca_pkg::ST_IDLE;
      endcase
   end
endmodule
